// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: a implies b");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: a implies b next cycle");

`endif

// ===== src/hsa_pkg.sv =====
// types and constants of the hsv saturation adjust pipeline
package hsa_pkg;

    localparam int DIV_BITS   = 8;
    localparam int REM_W      = 16;
    localparam int NUM_STAGES = 13;

    localparam logic [7:0]  HUE_HALF_TURN = 8'd180;
    localparam logic [12:0] BACK_SCALE    = 13'd7650;
    // ceil(2^36 / 7650), exact floor division for numerators below 2^21
    localparam logic [23:0] BACK_RECIP    = 24'd8982939;
    localparam int          RECIP_SHIFT   = 36;

    localparam logic CFG_OUTPUT_MODE = 1'b0;
    localparam logic CFG_SAT_GAIN    = 1'b1;

    localparam logic       MODE_HSV       = 1'b0;
    localparam logic [9:0] GAIN_RESET     = 10'd384;
    localparam logic       MODE_RESET     = 1'b1;

    typedef struct packed {
        logic [REM_W-1:0]    hrem;
        logic [7:0]          hdiv;
        logic [DIV_BITS-1:0] hq;
        logic [REM_W-1:0]    srem;
        logic [7:0]          sdiv;
        logic [DIV_BITS-1:0] sq;
        logic [7:0]          val;
        logic                neg;
        logic                grey;
    } t_div;

endpackage

// ===== src/hsa_in_if.sv =====
// request channel carrying one bgr pixel
interface hsa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    input ready);
    modport sink   (input valid, input blue_in, input green_in, input red_in,
                    output ready);
endinterface

// ===== src/hsa_out_if.sv =====
// request channel carrying one result triple
interface hsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;

    modport source (output valid, output out_a, output out_b, output out_c,
                    input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c,
                    output ready);
endinterface

// ===== src/hsa_hsv_front.sv =====
// max, min, delta and dividend setup for hue and saturation
module hsa_hsv_front (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_red,
    output hsa_pkg::t_div o_div
);
    logic [7:0]  mx, mn, d;
    logic [15:0] b16, g16, r16, d16;
    hsa_pkg::t_div n_div, r_div;

    always_comb begin
        b16 = {8'd0, i_blue};
        g16 = {8'd0, i_green};
        r16 = {8'd0, i_red};
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        d   = mx - mn;
        d16 = {8'd0, d};

        n_div      = '0;
        n_div.hdiv = d;
        n_div.sdiv = mx;
        n_div.srem = 16'd255 * d16;
        n_div.val  = mx;
        n_div.grey = (d == 8'd0);
        n_div.neg  = 1'b0;
        priority if (i_red >= i_green && i_red >= i_blue) begin
            if (i_green >= i_blue) begin
                n_div.hrem = 16'd30 * (g16 - b16);
            end else begin
                n_div.hrem = 16'd30 * (b16 - g16) + d16 - 16'd1;
                n_div.neg  = 1'b1;
            end
        end else if (i_green >= i_blue) begin
            n_div.hrem = 16'd60 * d16 + 16'd30 * b16 - 16'd30 * r16;
        end else begin
            n_div.hrem = 16'd120 * d16 + 16'd30 * r16 - 16'd30 * g16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_div <= n_div;
    end

    assign o_div = r_div;
endmodule

// ===== src/hsa_div_step.sv =====
// one restoring quotient bit for the hue and saturation divides
module hsa_div_step #(
    parameter int BIT = 7
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  hsa_pkg::t_div i_div,
    output hsa_pkg::t_div o_div
);
    logic [hsa_pkg::REM_W-1:0] hsh, ssh;
    hsa_pkg::t_div n_div, r_div;

    always_comb begin
        hsh   = {8'd0, i_div.hdiv} << BIT;
        ssh   = {8'd0, i_div.sdiv} << BIT;
        n_div = i_div;
        if (i_div.hrem >= hsh) begin
            n_div.hrem    = i_div.hrem - hsh;
            n_div.hq[BIT] = 1'b1;
        end
        if (i_div.srem >= ssh) begin
            n_div.srem    = i_div.srem - ssh;
            n_div.sq[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_div <= n_div;
    end

    assign o_div = r_div;
endmodule

// ===== src/hsa_rgb_back.sv =====
// hue fixup, gain rounding and sector conversion back to bgr, or hsv output by mode
module hsa_rgb_back (
    input  logic          i_clk,
    input  logic [3:0]    i_en,
    input  hsa_pkg::t_div i_div,
    input  logic          i_mode,
    input  logic [9:0]    i_gain,
    output logic [7:0]    o_a,
    output logic [7:0]    o_b,
    output logic [7:0]    o_c
);
    // stage one: finished hsv and gain product
    logic [7:0]  n1_h, n1_s, r1_h, r1_s, r1_v;
    logic [17:0] n1_prod, r1_prod;
    // stage two: rounded saturation and per-channel weights
    logic [9:0]  qr;
    logic [10:0] qs;
    logic [7:0]  sat, t;
    logic [4:0]  k, kr, kg, kb;
    logic [12:0] n2_wr, n2_wg, n2_wb, r2_wr, r2_wg, r2_wb;
    logic [7:0]  r2_h, r2_s, r2_v;
    // stage three: scaled numerators
    logic [20:0] n3_nr, n3_ng, n3_nb, r3_nr, r3_ng, r3_nb;
    logic [7:0]  r3_h, r3_s, r3_v;
    // stage four: reciprocal divide and mode select
    logic [44:0] pr, pg, pb;
    logic [7:0]  n4_a, n4_b, n4_c, r4_a, r4_b, r4_c;

    always_comb begin
        n1_h = i_div.neg ? hsa_pkg::HUE_HALF_TURN - i_div.hq : i_div.hq;
        n1_s = i_div.sq;
        if (i_div.grey) begin
            n1_h = 8'd0;
            n1_s = 8'd0;
        end
        n1_prod = {10'd0, n1_s} * {8'd0, i_gain};
    end

    always_comb begin
        qr = r1_prod[17:8];
        qs = {1'b0, qr};
        if (r1_prod[7:0] > 8'd128 || (r1_prod[7:0] == 8'd128 && qr[0])) begin
            qs = {1'b0, qr} + 11'd1;
        end
        sat = (qs > 11'd255) ? 8'd255 : qs[7:0];

        priority if (r1_h < 8'd60) t = r1_h;
        else if (r1_h < 8'd120) t = r1_h - 8'd60;
        else t = r1_h - 8'd120;
        k = (t < 8'd30) ? t[4:0] : 5'(8'd60 - t);

        priority if (r1_h < 8'd30) begin
            kr = 5'd30; kg = k; kb = 5'd0;
        end else if (r1_h < 8'd60) begin
            kr = k; kg = 5'd30; kb = 5'd0;
        end else if (r1_h < 8'd90) begin
            kr = 5'd0; kg = 5'd30; kb = k;
        end else if (r1_h < 8'd120) begin
            kr = 5'd0; kg = k; kb = 5'd30;
        end else if (r1_h < 8'd150) begin
            kr = k; kg = 5'd0; kb = 5'd30;
        end else begin
            kr = 5'd30; kg = 5'd0; kb = k;
        end
        n2_wr = {5'd0, sat} * {8'd0, 5'd30 - kr};
        n2_wg = {5'd0, sat} * {8'd0, 5'd30 - kg};
        n2_wb = {5'd0, sat} * {8'd0, 5'd30 - kb};
    end

    always_comb begin
        n3_nr = {13'd0, r2_v} * {8'd0, hsa_pkg::BACK_SCALE - r2_wr};
        n3_ng = {13'd0, r2_v} * {8'd0, hsa_pkg::BACK_SCALE - r2_wg};
        n3_nb = {13'd0, r2_v} * {8'd0, hsa_pkg::BACK_SCALE - r2_wb};
    end

    always_comb begin
        pr = {24'd0, r3_nr} * {21'd0, hsa_pkg::BACK_RECIP};
        pg = {24'd0, r3_ng} * {21'd0, hsa_pkg::BACK_RECIP};
        pb = {24'd0, r3_nb} * {21'd0, hsa_pkg::BACK_RECIP};
        if (i_mode == hsa_pkg::MODE_HSV) begin
            n4_a = r3_h;
            n4_b = r3_s;
            n4_c = r3_v;
        end else begin
            n4_a = pb[hsa_pkg::RECIP_SHIFT +: 8];
            n4_b = pg[hsa_pkg::RECIP_SHIFT +: 8];
            n4_c = pr[hsa_pkg::RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_h    <= n1_h;
            r1_s    <= n1_s;
            r1_v    <= i_div.val;
            r1_prod <= n1_prod;
        end
        if (i_en[1]) begin
            r2_h  <= r1_h;
            r2_s  <= r1_s;
            r2_v  <= r1_v;
            r2_wr <= n2_wr;
            r2_wg <= n2_wg;
            r2_wb <= n2_wb;
        end
        if (i_en[2]) begin
            r3_h  <= r2_h;
            r3_s  <= r2_s;
            r3_v  <= r2_v;
            r3_nr <= n3_nr;
            r3_ng <= n3_ng;
            r3_nb <= n3_nb;
        end
        if (i_en[3]) begin
            r4_a <= n4_a;
            r4_b <= n4_b;
            r4_c <= n4_c;
        end
    end

    assign o_a = r4_a;
    assign o_b = r4_b;
    assign o_c = r4_c;
endmodule

// ===== src/hsv_saturation_adjust.sv =====
// top level: bgr to hsv with saturation gain, thirteen-stage pipeline
// result valid comes from the last of the 13 register stages
// throughput: one pixel per cycle while the output is not stalled; the divides run one quotient bit per stage
// each stage holds its own valid bit, so bubbles fill while the output stalls
// reset (i_rst_n low, synchronous) empties the pipeline, sets mode 1, gain 384
module hsv_saturation_adjust (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [9:0] i_cfg_data,
    hsa_in_if.sink     i_pix,
    hsa_out_if.source  o_res
);
    `include "assert_macros.svh"

    localparam int NS = hsa_pkg::NUM_STAGES;

    // configuration registers
    logic       r_output_mode;
    logic [9:0] r_saturation_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_mode     <= hsa_pkg::MODE_RESET;
            r_saturation_gain <= hsa_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsa_pkg::CFG_OUTPUT_MODE: r_output_mode     <= i_cfg_data[0];
                hsa_pkg::CFG_SAT_GAIN:    r_saturation_gain <= i_cfg_data;
                default:                  r_output_mode     <= r_output_mode;
            endcase
        end
    end

    // valid bit per stage; a stage loads when it is empty or its successor moves
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_res.ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_pix.valid;
            for (int i = 1; i < NS; i++) begin
                if (en[i]) r_vld[i] <= r_vld[i-1];
            end
        end
    end

    assign i_pix.ready = en[0];

    // stage 0: extremes, delta and dividends
    hsa_pkg::t_div w_div [0:hsa_pkg::DIV_BITS];

    hsa_hsv_front u_front (
        .i_clk   (i_clk),
        .i_en    (en[0]),
        .i_blue  (i_pix.blue_in),
        .i_green (i_pix.green_in),
        .i_red   (i_pix.red_in),
        .o_div   (w_div[0])
    );

    // stages 1..8: hue and saturation quotients, msb first
    for (genvar gi = 0; gi < hsa_pkg::DIV_BITS; gi++) begin : g_div
        hsa_div_step #(
            .BIT (hsa_pkg::DIV_BITS - 1 - gi)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (en[gi+1]),
            .i_div (w_div[gi]),
            .o_div (w_div[gi+1])
        );
    end

    // stages 9..12: gain, sectors, scaling, reciprocal divide, output register
    hsa_rgb_back u_back (
        .i_clk  (i_clk),
        .i_en   (en[NS-1:NS-4]),
        .i_div  (w_div[hsa_pkg::DIV_BITS]),
        .i_mode (r_output_mode),
        .i_gain (r_saturation_gain),
        .o_a    (o_res.out_a),
        .o_b    (o_res.out_b),
        .o_c    (o_res.out_c)
    );

    assign o_res.valid = r_vld[NS-1];

    // hue never leaves 0..179
    `ASSERT_IMPLY(a_hue_range, i_clk, i_rst_n,
        o_res.valid && r_output_mode == hsa_pkg::MODE_HSV, o_res.out_a < 8'd180)
    // black pixel has zero saturation
    `ASSERT_IMPLY(a_black_sat, i_clk, i_rst_n,
        o_res.valid && r_output_mode == hsa_pkg::MODE_HSV && o_res.out_c == 8'd0,
        o_res.out_b == 8'd0)
    // input only blocks when every stage is full
    `ASSERT_IMPLY(a_full_stall, i_clk, i_rst_n, !i_pix.ready, &r_vld)
    // an accepted request occupies the first stage
    `ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_pix.valid && i_pix.ready, r_vld[0])
endmodule
